@@ design/lrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared constants for the linear ramp smoother: default widths and command
// codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

    localparam int WORD_BITS          = 32;
    localparam int DEF_FRACTION_BITS  = 16;
    localparam int DEF_COUNT_BITS     = 20;

    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_LATCH   = 1'b1;

endpackage

`default_nettype wire

@@ design/linear_ramp_smoother_core.sv @@
// ----------------------------------------------------------------------------
// linear_ramp_smoother_core
// Ramps a Q32.16 control value linearly to a latched target over a
// configured number of samples, using a serial divider for the step.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command word:
//   advance (one smoothed sample) or latch (take i_new_target).
//   Output channel (o_out_valid / i_out_ready) returns one word per input
//   word: o_level and o_ramping.
//   Config channel (i_cfg_valid / o_cfg_ready) writes ramp_samples; it is
//   always ready, and the user must write it only while the block is idle;
//   the block itself does not enforce this.
// Result timing:
//   advance, a latch of an unchanged target, or a latch with ramp_samples
//   zero: result registered in the cycle after acceptance, one word per cycle
//   while the output is free. latch of a new target with a nonzero length:
//   the restoring divider runs ACC_BITS steps, one quotient bit per cycle,
//   then a finish state registers the result; no input is taken meanwhile.
// Reset: accumulator, target, step, count and ramp_samples all clear to zero.
// Stall: a result waits in the output register; a new word is accepted in
//   the same cycle the waiting one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_ramp_smoother_core #(
    parameter int FRACTION_BITS = lrs_pkg::DEF_FRACTION_BITS,
    parameter int COUNT_BITS    = lrs_pkg::DEF_COUNT_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input words
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_command,
    input  wire logic signed [lrs_pkg::WORD_BITS-1:0] i_new_target,
    // result words
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [lrs_pkg::WORD_BITS-1:0] o_level,
    output logic                                o_ramping,
    // configuration
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [COUNT_BITS-1:0]          i_cfg_ramp_samples
);

    localparam int W        = lrs_pkg::WORD_BITS;
    localparam int ACC_BITS = W + FRACTION_BITS;
    localparam int CNT_W    = $clog2(ACC_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_ramp_samples;
    logic [ACC_BITS-1:0]   r_current, n_current;
    logic [W-1:0]          r_target, n_target;
    logic [ACC_BITS-1:0]   r_step, n_step;
    logic [COUNT_BITS-1:0] r_remaining, n_remaining;
    // divider: dividend shifts out of r_quo as quotient bits shift in
    logic [ACC_BITS-1:0]   r_quo, n_quo;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic                  r_neg, n_neg;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    logic [W-1:0]          r_out_level, n_out_level;
    logic                  r_out_ramping, n_out_ramping;

    logic                  w_in_accept;
    logic                  w_out_free;
    logic [ACC_BITS-1:0]   w_target_acc;
    logic [ACC_BITS:0]     w_diff;
    logic [ACC_BITS:0]     w_diff_neg;
    logic [COUNT_BITS:0]   w_trial;
    logic [COUNT_BITS:0]   w_sub;
    logic                  w_geq;
    logic [ACC_BITS-1:0]   w_sum;
    logic [COUNT_BITS-1:0] w_rem_dec;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && w_out_free;
    assign w_in_accept = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_level     = r_out_level;
    assign o_ramping   = r_out_ramping;

    assign w_target_acc = {i_new_target, {FRACTION_BITS{1'b0}}};
    assign w_diff       = {w_target_acc[ACC_BITS-1], w_target_acc}
                        - {r_current[ACC_BITS-1], r_current};
    assign w_diff_neg   = -w_diff;

    assign w_trial = {r_rem, r_quo[ACC_BITS-1]};
    assign w_geq   = w_trial >= {1'b0, r_remaining};
    assign w_sub   = w_trial - {1'b0, r_remaining};

    assign w_sum     = r_current + r_step;
    assign w_rem_dec = r_remaining - 1'b1;

    always_comb begin
        n_state       = r_state;
        n_current     = r_current;
        n_target      = r_target;
        n_step        = r_step;
        n_remaining   = r_remaining;
        n_quo         = r_quo;
        n_rem         = r_rem;
        n_neg         = r_neg;
        n_count       = r_count;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_level   = r_out_level;
        n_out_ramping = r_out_ramping;
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    if (i_command == lrs_pkg::CMD_ADVANCE) begin
                        n_out_valid = 1'b1;
                        if (r_remaining == '0) begin
                            n_out_level   = r_target;
                            n_out_ramping = 1'b0;
                        end else begin
                            n_remaining   = w_rem_dec;
                            n_current     = w_sum;
                            n_out_level   = w_sum[ACC_BITS-1:FRACTION_BITS];
                            n_out_ramping = (w_rem_dec != '0);
                        end
                    end else if (i_new_target == r_target) begin
                        // unchanged target: just report present level
                        n_out_valid   = 1'b1;
                        n_out_ramping = (r_remaining != '0);
                        n_out_level   = (r_remaining == '0) ? r_target
                                      : r_current[ACC_BITS-1:FRACTION_BITS];
                    end else begin
                        n_target    = i_new_target;
                        n_remaining = r_ramp_samples;
                        if (r_ramp_samples == '0) begin
                            n_current     = w_target_acc;
                            n_out_valid   = 1'b1;
                            n_out_level   = i_new_target;
                            n_out_ramping = 1'b0;
                        end else begin
                            // magnitude fits ACC_BITS, sign kept apart
                            n_neg   = w_diff[ACC_BITS];
                            n_quo   = w_diff[ACC_BITS] ? w_diff_neg[ACC_BITS-1:0]
                                                       : w_diff[ACC_BITS-1:0];
                            n_rem   = '0;
                            n_count = '0;
                            n_state = ST_DIVIDE;
                        end
                    end
                end
            end
            ST_DIVIDE: begin
                n_quo   = {r_quo[ACC_BITS-2:0], w_geq};
                n_rem   = w_geq ? w_sub[COUNT_BITS-1:0] : w_trial[COUNT_BITS-1:0];
                n_count = r_count + 1'b1;
                if (r_count == CNT_W'(ACC_BITS - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    // truncation toward zero: negate the magnitude quotient
                    n_step        = r_neg ? (~r_quo + 1'b1) : r_quo;
                    n_out_valid   = 1'b1;
                    n_out_level   = r_current[ACC_BITS-1:FRACTION_BITS];
                    n_out_ramping = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_ramp_samples <= '0;
            r_current      <= '0;
            r_target       <= '0;
            r_step         <= '0;
            r_remaining    <= '0;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_current   <= n_current;
            r_target    <= n_target;
            r_step      <= n_step;
            r_remaining <= n_remaining;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_ramp_samples <= i_cfg_ramp_samples;
            end
        end
        r_quo         <= n_quo;
        r_rem         <= n_rem;
        r_neg         <= n_neg;
        r_out_level   <= n_out_level;
        r_out_ramping <= n_out_ramping;
    end

    // an advance during a ramp counts down by one and produces a word
    a_advance_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_command == lrs_pkg::CMD_ADVANCE && r_remaining != '0)
        |=> (o_out_valid && r_remaining == COUNT_BITS'($past(r_remaining) - 1'b1)))
        else $error("advance did not count down");

    // a new target with nonzero length starts the divider
    a_latch_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_command == lrs_pkg::CMD_LATCH && i_new_target != r_target
         && r_ramp_samples != '0)
        |=> (r_state == ST_DIVIDE && r_count == '0))
        else $error("latch did not start divide");

    // the divide step counter stays within the ACC_BITS divide steps
    a_divide_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE) |-> (r_count <= CNT_W'(ACC_BITS - 1)))
        else $error("divide count out of range");

    // divider partial remainder stays below the divisor
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE && r_count != '0) |-> (r_rem < r_remaining))
        else $error("divide remainder overflow");

endmodule

`default_nettype wire
